>>> rtl/olpi_pkg.sv
// Shared types and constants for the ordered list with positional insert.
package olpi_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned ST_W  = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             rot;
    logic [CNT_W-1:0] at;
    logic [CNT_W-1:0] tail;
    logic [VAL_W-1:0] value;
  } olpi_cmd_t;

endpackage

>>> rtl/olpi_cell.sv
// One storage cell of the list chain: holds one element and moves with its neighbours.
module olpi_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                         clk_i,
  input  olpi_pkg::olpi_cmd_t          cmd_i,
  input  logic [olpi_pkg::VAL_W-1:0]   left_i,
  input  logic [olpi_pkg::VAL_W-1:0]   right_i,
  input  logic [olpi_pkg::VAL_W-1:0]   head_i,
  output logic [olpi_pkg::VAL_W-1:0]   value_o
);
  import olpi_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(CELL_IDX);

  logic [VAL_W-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      // Entries at and after the target move back by one place.
      if (MyIdx > cmd_i.at) begin
        val_d = left_i;
      end else if (MyIdx == cmd_i.at) begin
        val_d = cmd_i.value;
      end
    end else if (cmd_i.rot) begin
      // The occupied part turns round by one, the head wrapping to the tail.
      if (MyIdx == cmd_i.tail) begin
        val_d = head_i;
      end else if (MyIdx < cmd_i.tail) begin
        val_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

>>> rtl/ordered_list_positional_insert.sv
// Insert: result registered from the request; dump: one result per cycle while not stalled.
// An insert shifts the chain of cells at once; inserts run one per cycle unless stalled.
// A dump sets the dump flag, then rotates the chain once per result, ending back in order.
// Requests are not taken while a dump is in progress or the output register is stalled.
// Reset empties the list and the output register; no clearing pass is needed.
module ordered_list_positional_insert #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value [31:0], position [39:32]
  input  logic [0:0]  s_axis_tuser,  // op [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // item_value [31:0], item_index [37:32], count [44:38]
  output logic [1:0]  m_axis_tuser,  // status [1:0]
  output logic        m_axis_tlast
);
  import olpi_pkg::*;

  localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

  logic [VAL_W-1:0] cell_val [CAPACITY];
  olpi_cmd_t        cmd;

  logic [CNT_W-1:0] occ_q, occ_d;
  logic             dump_q, dump_d;
  logic [IDX_W-1:0] didx_q, didx_d;

  logic             ovld_q, ovld_d;
  logic [VAL_W-1:0] oval_q, oval_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;
  logic [ST_W-1:0]  ost_q, ost_d;
  logic             olast_q, olast_d;

  logic             out_free, acc, step, full, is_last;
  logic [POS_W-1:0] pos, at_raw;
  logic [CNT_W-1:0] at;

  assign out_free      = !ovld_q || m_axis_tready;
  assign s_axis_tready = !dump_q && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign step          = dump_q && out_free;
  assign full          = (occ_q >= Cap);

  assign pos    = s_axis_tdata[39:32];
  assign at_raw = (pos <= POS_W'(1)) ? '0 : pos - POS_W'(1);
  assign at     = (at_raw > POS_W'(occ_q)) ? occ_q : at_raw[CNT_W-1:0];

  assign is_last = (CNT_W'(didx_q) == occ_q - CNT_W'(1));

  always_comb begin
    cmd.ins   = acc && (s_axis_tuser[0] == OP_INSERT) && !full;
    cmd.rot   = step;
    cmd.at    = at;
    cmd.tail  = occ_q - CNT_W'(1);
    cmd.value = s_axis_tdata[31:0];
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_mid
      assign left = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = cell_val[0];
    end else begin : g_inner
      assign right = cell_val[g+1];
    end
    olpi_cell #(.CELL_IDX(g)) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_val[0]),
      .value_o (cell_val[g])
    );
  end

  always_comb begin
    occ_d   = occ_q;
    dump_d  = dump_q;
    didx_d  = didx_q;
    ovld_d  = ovld_q && !m_axis_tready;
    oval_d  = oval_q;
    oidx_d  = oidx_q;
    ocnt_d  = ocnt_q;
    ost_d   = ost_q;
    olast_d = olast_q;
    if (acc) begin
      oval_d  = '0;
      oidx_d  = '0;
      olast_d = 1'b1;
      if (s_axis_tuser[0] == OP_INSERT) begin
        ovld_d = 1'b1;
        if (full) begin
          ocnt_d = occ_q;
          ost_d  = ST_FULL;
        end else begin
          occ_d  = occ_q + CNT_W'(1);
          ocnt_d = occ_q + CNT_W'(1);
          ost_d  = ST_OK;
        end
      end else if (occ_q == '0) begin
        ovld_d = 1'b1;
        ocnt_d = '0;
        ost_d  = ST_EMPTY;
      end else begin
        dump_d = 1'b1;
        didx_d = '0;
      end
    end else if (step) begin
      ovld_d  = 1'b1;
      oval_d  = cell_val[0];
      oidx_d  = didx_q;
      ocnt_d  = occ_q;
      ost_d   = ST_OK;
      olast_d = is_last;
      didx_d  = didx_q + IDX_W'(1);
      if (is_last) begin
        dump_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      dump_q <= 1'b0;
      didx_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      dump_q <= dump_d;
      didx_q <= didx_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oval_q  <= oval_d;
    oidx_q  <= oidx_d;
    ocnt_q  <= ocnt_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {3'b000, ocnt_q, oidx_q, oval_q};
  assign m_axis_tuser  = ost_q;
  assign m_axis_tlast  = olast_q;

endmodule

>>> rtl/olpi_checker.sv
// Port-level checks for the ordered list, bound to the top level.
module olpi_checker #(
  parameter int unsigned CAPACITY = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import olpi_pkg::*;

  // The list never reports more elements than it can hold.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[44:38] <= CNT_W'(CAPACITY)))
    else $error("count above capacity");

  // Full and empty results are always single results.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tlast)
    else $error("status result without last mark");

  // An empty dump reports an empty list.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == ST_EMPTY) |-> (m_axis_tdata[44:38] == '0))
    else $error("empty status with nonzero count");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output changed while stalled");

endmodule

bind ordered_list_positional_insert olpi_checker #(.CAPACITY(CAPACITY)) u_olpi_checker (.*);
